FILE: src/fly_camera_update_top_macros.svh
`ifndef FLY_CAMERA_UPDATE_TOP_MACROS_SVH
`define FLY_CAMERA_UPDATE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define FCU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fcu check failed");

// next-cycle implication, off during reset
`define FCU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fcu check failed");

// next-cycle implication, also checked through reset
`define FCU_ASSERT_NXT_ALL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("fcu check failed");

`endif

FILE: src/fcu_pkg.sv
package fcu_pkg;

  // default sizes
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int POSITION_BITS_DEF = 32;

  // shift-add multiplier operand widths, shared by both multiplier instances
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [15:0] SPEED_RESET = 16'd1280;

  // quarter sine polynomial coefficients
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [15:0] POLY_B = 16'd42047;
  localparam logic [12:0] POLY_C = 13'd4640;

  localparam logic [15:0] Q14_ONE = 16'd16384;

  // rounding offsets for full products and saturation bounds for the shifted results
  localparam logic signed [MUL_PW-1:0] RND14  = MUL_PW'(8192);
  localparam logic signed [MUL_PW-1:0] RND22  = MUL_PW'(2097152);
  localparam logic signed [MUL_PW-1:0] SAT_HI = MUL_PW'(16384);
  localparam logic signed [MUL_PW-1:0] SAT_LO = MUL_PW'(-16384);

  typedef struct packed {
    logic [15:0]        frame_time;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic               key_forward;
    logic               key_back;
    logic               key_left;
    logic               key_right;
    logic               drag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  typedef enum logic [2:0] {
    SIN_IDLE,
    SIN_SQ,
    SIN_C,
    SIN_T,
    SIN_A
  } sine_state_t;

  typedef enum logic [4:0] {
    M_IDLE,
    M_SH0,
    M_CH0,
    M_D,
    M_AX,
    M_AZ,
    M_TH,
    M_TT,
    M_SH,
    M_CH,
    M_ST,
    M_CT,
    M_FX,
    M_FZ,
    M_UX,
    M_UZ,
    M_U1,
    M_U2,
    M_OUT
  } main_state_t;

  // round half up from Q28 to Q14 and limit to one
  function automatic logic signed [15:0] rnd_sat14(input logic signed [MUL_PW-1:0] p);
    logic signed [MUL_PW-1:0] r;
    r = (p + RND14) >>> 14;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return 16'(r);
  endfunction

endpackage

FILE: src/fly_camera_update_top.sv
// the block takes no new frame until its result has entered the output register; the sequence
// is six quarter sine evaluations of four 18-step shift-add multiplies each plus nine more
// such multiplies, eleven when drag is high
// reset: heading, tilt, position, last cursor and seen flag clear, move_speed goes to 5.0,
// the output register empties and the block is ready for a frame on the next cycle
module fly_camera_update_top import fcu_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int TILT_W = 40;
  localparam logic [63:0] TURN_STEP =
    (64'd1591549431 * (64'd1 << ANGLE_BITS) + 64'd500000000000) / 64'd1000000000000;
  localparam logic [63:0] TILT_LIMIT =
    (64'd238732415 * (64'd1 << ANGLE_BITS) + 64'd500000000) / 64'd1000000000;
  localparam logic signed [MUL_BW-1:0] TS_B   = MUL_BW'(TURN_STEP);
  localparam logic signed [TILT_W-1:0] TL_HI  = TILT_W'(TILT_LIMIT);
  localparam logic signed [TILT_W-1:0] TL_LO  = -TL_HI;
  localparam logic [ANGLE_BITS-1:0]    QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  main_state_t state, state_next, succ;
  logic        issued, issued_next;

  // persistent state
  logic [15:0]                     move_speed;
  logic [ANGLE_BITS-1:0]           heading;
  logic signed [ANGLE_BITS-1:0]    tilt;
  logic signed [POSITION_BITS-1:0] pos_x, pos_z;
  logic signed [15:0]              last_x, last_y;
  logic                            seen;

  // per-frame working registers
  logic [15:0]          ftime;
  logic                 kf, kb, kl, kr, drag_r;
  logic signed [16:0]   dx, dy;
  logic signed [15:0]   sh, ch, st, ct, fx, fz, ux, uz, uy;
  logic [31:0]          travel;
  logic signed [MUL_PW-1:0] p1;

  logic                 in_xfer, out_free, is_sine, is_mul, unit_done;
  logic                 sine_start, sine_done, mul_start, mul_done;
  logic [ANGLE_BITS-1:0] sine_angle;
  logic signed [15:0]   sine_val;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p, pstep;
  logic signed [17:0]   sh_e, ch_e, ax, az;
  logic signed [TILT_W-1:0] tilt_raw, tilt_clamp;

  assign in_stall  = (state != M_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // movement direction from keys, opposing keys cancel
  always_comb begin
    sh_e = 18'(sh);
    ch_e = 18'(ch);
    ax   = '0;
    az   = '0;
    if (kf && !kb) begin
      ax = ax + sh_e;
      az = az + ch_e;
    end else if (kb && !kf) begin
      ax = ax - sh_e;
      az = az - ch_e;
    end
    if (kl && !kr) begin
      ax = ax + ch_e;
      az = az - sh_e;
    end else if (kr && !kl) begin
      ax = ax - ch_e;
      az = az + sh_e;
    end
  end

  // unit kind per step
  always_comb begin
    is_sine = (state == M_SH0) || (state == M_CH0) || (state == M_SH) ||
              (state == M_CH) || (state == M_ST) || (state == M_CT);
    is_mul  = !is_sine && (state != M_IDLE) && (state != M_OUT);
    unit_done = is_sine ? sine_done : mul_done;
  end

  // sine angle select
  always_comb begin
    unique case (state)
      M_CH0, M_CH: sine_angle = heading + QUARTER;
      M_ST:        sine_angle = tilt;
      M_CT:        sine_angle = tilt + QUARTER;
      default:     sine_angle = heading;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      M_D: begin
        mul_a = MUL_AW'(move_speed);
        mul_b = MUL_BW'(ftime);
      end
      M_AX: begin
        mul_a = MUL_AW'(travel);
        mul_b = ax;
      end
      M_AZ: begin
        mul_a = MUL_AW'(travel);
        mul_b = az;
      end
      M_TH: begin
        mul_a = MUL_AW'(dx);
        mul_b = TS_B;
      end
      M_TT: begin
        mul_a = MUL_AW'(dy);
        mul_b = TS_B;
      end
      M_FX: begin
        mul_a = MUL_AW'(sh);
        mul_b = MUL_BW'(ct);
      end
      M_FZ: begin
        mul_a = MUL_AW'(ch);
        mul_b = MUL_BW'(ct);
      end
      M_UX: begin
        mul_a = MUL_AW'(sh);
        mul_b = MUL_BW'(st);
      end
      M_UZ: begin
        mul_a = MUL_AW'(ch);
        mul_b = MUL_BW'(st);
      end
      M_U1: begin
        mul_a = -MUL_AW'(sh);
        mul_b = MUL_BW'(fx);
      end
      M_U2: begin
        mul_a = MUL_AW'(ch);
        mul_b = MUL_BW'(fz);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  fcu_sine #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (sine_start),
    .angle (sine_angle),
    .done  (sine_done),
    .value (sine_val)
  );

  fcu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // step order
  always_comb begin
    unique case (state)
      M_IDLE: succ = M_SH0;
      M_SH0:  succ = M_CH0;
      M_CH0:  succ = M_D;
      M_D:    succ = M_AX;
      M_AX:   succ = M_AZ;
      M_AZ:   succ = drag_r ? M_TH : M_SH;
      M_TH:   succ = M_TT;
      M_TT:   succ = M_SH;
      M_SH:   succ = M_CH;
      M_CH:   succ = M_ST;
      M_ST:   succ = M_CT;
      M_CT:   succ = M_FX;
      M_FX:   succ = M_FZ;
      M_FZ:   succ = M_UX;
      M_UX:   succ = M_UZ;
      M_UZ:   succ = M_U1;
      M_U1:   succ = M_U2;
      M_U2:   succ = M_OUT;
      M_OUT:  succ = M_IDLE;
      default: succ = M_IDLE;
    endcase
  end

  // sequencer
  always_comb begin
    state_next  = state;
    issued_next = issued;
    sine_start  = 1'b0;
    mul_start   = 1'b0;
    priority if (state == M_IDLE) begin
      if (in_xfer) begin
        state_next  = succ;
        issued_next = 1'b0;
      end
    end else if (state == M_OUT) begin
      if (out_free) begin
        state_next = succ;
      end
    end else begin
      if (!issued) begin
        sine_start  = is_sine;
        mul_start   = is_mul;
        issued_next = 1'b1;
      end else if (unit_done) begin
        state_next  = succ;
        issued_next = 1'b0;
      end
    end
  end

  // position step and new tilt
  always_comb begin
    pstep      = (mul_p + RND22) >>> 22;
    tilt_raw   = TILT_W'(tilt) - TILT_W'(mul_p);
    tilt_clamp = tilt_raw;
    if (tilt_raw > TL_HI) begin
      tilt_clamp = TL_HI;
    end else if (tilt_raw < TL_LO) begin
      tilt_clamp = TL_LO;
    end
  end

  // control and camera state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= M_IDLE;
      issued     <= 1'b0;
      out_valid  <= 1'b0;
      move_speed <= SPEED_RESET;
      heading    <= '0;
      tilt       <= '0;
      pos_x      <= '0;
      pos_z      <= '0;
      last_x     <= '0;
      last_y     <= '0;
      seen       <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      if (cfg_valid && cfg_ready) begin
        move_speed <= cfg_data;
      end
      if (in_xfer) begin
        seen   <= 1'b1;
        last_x <= in_data.cursor_x;
        last_y <= in_data.cursor_y;
      end
      if (issued && mul_done) begin
        unique case (state)
          M_AX:    pos_x   <= pos_x + pstep[POSITION_BITS-1:0];
          M_AZ:    pos_z   <= pos_z + pstep[POSITION_BITS-1:0];
          M_TH:    heading <= heading - mul_p[ANGLE_BITS-1:0];
          M_TT:    tilt    <= ANGLE_BITS'(tilt_clamp);
          default: begin
          end
        endcase
      end
      // output register
      if (state == M_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ftime  <= in_data.frame_time;
      kf     <= in_data.key_forward;
      kb     <= in_data.key_back;
      kl     <= in_data.key_left;
      kr     <= in_data.key_right;
      drag_r <= in_data.drag;
      dx     <= seen ? (17'(in_data.cursor_x) - 17'(last_x)) : '0;
      dy     <= seen ? (17'(in_data.cursor_y) - 17'(last_y)) : '0;
    end
    if (issued && sine_done) begin
      unique case (state)
        M_SH0, M_SH: sh <= sine_val;
        M_CH0, M_CH: ch <= sine_val;
        M_ST:        st <= sine_val;
        M_CT:        ct <= sine_val;
        default: begin
        end
      endcase
    end
    if (issued && mul_done) begin
      unique case (state)
        M_D:  travel <= mul_p[31:0];
        M_FX: fx   <= rnd_sat14(mul_p);
        M_FZ: fz   <= rnd_sat14(mul_p);
        M_UX: ux   <= rnd_sat14(mul_p);
        M_UZ: uz   <= rnd_sat14(mul_p);
        M_U1: p1   <= mul_p;
        M_U2: uy   <= rnd_sat14(p1 - mul_p);
        default: begin
        end
      endcase
    end
    if (state == M_OUT && out_free) begin
      out_data.pos_x   <= 32'(pos_x);
      out_data.pos_z   <= 32'(pos_z);
      out_data.fwd_x   <= fx;
      out_data.fwd_y   <= st;
      out_data.fwd_z   <= fz;
      out_data.right_x <= ch;
      out_data.right_z <= -sh;
      out_data.up_x    <= ux;
      out_data.up_y    <= uy;
      out_data.up_z    <= uz;
    end
  end

endmodule

FILE: src/fcu_mul.sv
module fcu_mul import fcu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] prod
);

  localparam int CW = $clog2(MUL_BW);

  logic                     busy;
  logic [CW-1:0]            cnt;
  logic signed [MUL_PW-1:0] mcand;
  logic [MUL_BW-1:0]        mplier;
  logic signed [MUL_PW-1:0] addend;

  // one multiplier bit per cycle, top bit carries negative weight
  always_comb begin
    addend = '0;
    if (mplier[0]) begin
      addend = (cnt == CW'(MUL_BW - 1)) ? -mcand : mcand;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand  <= MUL_PW'(a);
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      prod   <= prod + addend;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

FILE: src/fcu_sine.sv
module fcu_sine import fcu_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output logic signed [15:0]    value
);

  localparam int FW = ANGLE_BITS - 2;

  sine_state_t state, state_next;
  logic        issued, issued_next;
  logic        mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;

  logic [FW+15:0] frac_wide;
  logic [16:0]    u, x_in;
  logic           neg;
  logic [16:0]    x, x2, w;
  logic [15:0]    tq;
  logic [17:0]    yr;
  logic [15:0]    mag;

  // quadrant fold: fraction of a quarter turn scaled to 16 bits
  always_comb begin
    frac_wide = {angle[FW-1:0], 16'b0} >> FW;
    u         = frac_wide[16:0];
    x_in      = angle[FW] ? (17'd65536 - u) : u;
  end

  // operand select per polynomial step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      SIN_SQ: begin
        mul_a = MUL_AW'(x);
        mul_b = MUL_BW'(x);
      end
      SIN_C: begin
        mul_a = MUL_AW'(x2);
        mul_b = MUL_BW'(POLY_C);
      end
      SIN_T: begin
        mul_a = MUL_AW'(tq);
        mul_b = MUL_BW'(x2);
      end
      SIN_A: begin
        mul_a = MUL_AW'(w);
        mul_b = MUL_BW'(x);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  fcu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // sequencer
  always_comb begin
    state_next  = state;
    issued_next = issued;
    mul_start   = 1'b0;
    unique case (state)
      SIN_IDLE: begin
        if (start) begin
          state_next  = SIN_SQ;
          issued_next = 1'b0;
        end
      end
      SIN_SQ, SIN_C, SIN_T, SIN_A: begin
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          unique case (state)
            SIN_SQ:  state_next = SIN_C;
            SIN_C:   state_next = SIN_T;
            SIN_T:   state_next = SIN_A;
            default: state_next = SIN_IDLE;
          endcase
        end
      end
      default: begin
        state_next = SIN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SIN_IDLE;
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      done   <= (state == SIN_A) && issued && mul_done;
    end
  end

  // final rounding to q14 and limit
  always_comb begin
    yr  = 18'(mul_p[32:16]) + 18'd2;
    mag = (yr[17:2] > Q14_ONE) ? Q14_ONE : yr[17:2];
  end

  // step results
  always_ff @(posedge clk) begin
    if (state == SIN_IDLE && start) begin
      neg <= angle[ANGLE_BITS-1];
      x   <= x_in;
    end
    if (issued && mul_done) begin
      unique case (state)
        SIN_SQ: x2 <= mul_p[32:16];
        SIN_C:  tq <= POLY_B - mul_p[31:16];
        SIN_T:  w  <= POLY_A - mul_p[32:16];
        SIN_A:  value <= neg ? -signed'(mag) : signed'(mag);
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/fcu_checker.sv
`include "fly_camera_update_top_macros.svh"

module fcu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // reset empties the output register
  `FCU_ASSERT_NXT_ALL(a_reset_empty, rst, !out_valid)

  // a frame transfer makes the block busy
  `FCU_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // a result only appears at the end of a busy frame
  `FCU_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

  // a stalled result stays offered
  `FCU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind fly_camera_update_top fcu_checker u_fcu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

FILE: tb/fly_camera_update_top_tb.sv
module fly_camera_update_top_tb import fcu_pkg::*; ();

  localparam int TURN = 104;
  localparam int TILT_MAX = 15646;
  localparam int PHASE_ITEMS = 370;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // camera state as the predictor sees it
  logic [15:0] cam_speed;
  logic [15:0] cam_heading;
  longint      cam_tilt;
  logic [31:0] cam_px, cam_pz;
  longint      cam_last_x, cam_last_y;
  bit          cam_seen;

  out_item_t   pending_frames[$];
  int          mismatches = 0;
  int          frames_sent = 0;
  int          frames_seen = 0;
  bit          calm = 1'b0;

  // directed frames: extremes, each key, opposing keys, drag and tilt clamp
  frame_row_t dir_rows[14] = '{
    '{{16'h0000, 16'h0000, 16'h0000, 5'b00000}, 1'b1,
      {32'd0, 32'd0, 16'd0, 16'd0, 16'd16384, 16'd16384, 16'd0, 16'd0, 16'hC000, 16'd0}},
    '{{16'hFFFF, 16'h0000, 16'h0000, 5'b10000}, 1'b0, '0},
    '{{16'hFFFF, 16'h0000, 16'h0000, 5'b01000}, 1'b0, '0},
    '{{16'h8000, 16'h0000, 16'h0000, 5'b00100}, 1'b0, '0},
    '{{16'h8000, 16'h0000, 16'h0000, 5'b00010}, 1'b0, '0},
    '{{16'hFFFF, 16'h0000, 16'h0000, 5'b11110}, 1'b0, '0},
    '{{16'h1000, 16'd100,  16'h0000, 5'b00001}, 1'b0, '0},
    '{{16'h1000, 16'h7FFF, 16'h7FFF, 5'b10101}, 1'b0, '0},
    '{{16'h1000, 16'h8000, 16'h8000, 5'b10101}, 1'b0, '0},
    '{{16'h0000, 16'h7FFF, 16'h8000, 5'b00000}, 1'b0, '0},
    '{{16'hFFFF, 16'h8000, 16'h7FFF, 5'b01011}, 1'b0, '0},
    '{{16'h0001, 16'hFFF0, 16'h0010, 5'b11111}, 1'b0, '0},
    '{{16'hAAAA, 16'h5555, 16'hAAAA, 5'b10011}, 1'b0, '0},
    '{{16'h5555, 16'hAAAA, 16'h5555, 5'b01101}, 1'b0, '0}
  };

  fly_camera_update_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #60_000_000;
    $display("timeout at %0t", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // polynomial quarter sine, Q16 in, Q14 out
  function automatic longint quarter_sin(longint x);
    longint x2, t, y;
    x2 = (x * x) >> 16;
    t = 42047 - ((4640 * x2) >> 16);
    y = ((102944 - ((t * x2) >> 16)) * x) >> 16;
    y = (y + 2) >> 2;
    return (y > 16384) ? 16384 : y;
  endfunction

  function automatic longint angle_sin(logic [15:0] p);
    longint u, s;
    u = longint'(p[13:0]) << 2;
    s = quarter_sin(p[14] ? 65536 - u : u);
    return p[15] ? -s : s;
  endfunction

  function automatic longint angle_cos(logic [15:0] p);
    return angle_sin(p + 16'h4000);
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip14(longint v);
    return (v > 16384) ? 16384 : ((v < -16384) ? -16384 : v);
  endfunction

  // advance the camera by one frame and return the expected outputs
  function automatic out_item_t camera_frame(in_item_t f);
    longint dx, dy, sh, ch, st, ct, fb, lr, ax, az, d, t;
    longint fx, fy, fz, rx, rz;
    out_item_t o;
    dx = 0;
    dy = 0;
    if (cam_seen) begin
      dx = longint'(f.cursor_x) - cam_last_x;
      dy = longint'(f.cursor_y) - cam_last_y;
    end
    cam_seen = 1'b1;
    cam_last_x = f.cursor_x;
    cam_last_y = f.cursor_y;
    // movement along the heading held before the turn
    sh = angle_sin(cam_heading);
    ch = angle_cos(cam_heading);
    fb = longint'(f.key_forward) - longint'(f.key_back);
    lr = longint'(f.key_left) - longint'(f.key_right);
    ax = fb * sh + lr * ch;
    az = fb * ch - lr * sh;
    d = longint'(cam_speed) * longint'(f.frame_time);
    cam_px = cam_px + 32'(rnd_shift(ax * d, 22));
    cam_pz = cam_pz + 32'(rnd_shift(az * d, 22));
    // turn and clamp the tilt
    if (f.drag) begin
      cam_heading = cam_heading - 16'(dx * TURN);
      t = cam_tilt - dy * TURN;
      if (t > TILT_MAX) t = TILT_MAX;
      if (t < -TILT_MAX) t = -TILT_MAX;
      cam_tilt = t;
    end
    sh = angle_sin(cam_heading);
    ch = angle_cos(cam_heading);
    st = angle_sin(16'(cam_tilt));
    ct = angle_cos(16'(cam_tilt));
    fx = clip14(rnd_shift(ct * sh, 14));
    fy = clip14(st);
    fz = clip14(rnd_shift(ct * ch, 14));
    rx = clip14(ch);
    rz = clip14(-sh);
    o.pos_x = cam_px;
    o.pos_z = cam_pz;
    o.fwd_x = 16'(fx);
    o.fwd_y = 16'(fy);
    o.fwd_z = 16'(fz);
    o.right_x = 16'(rx);
    o.right_z = 16'(rz);
    o.up_x = 16'(clip14(rnd_shift(-rz * fy, 14)));
    o.up_y = 16'(clip14(rnd_shift(rz * fx - rx * fz, 14)));
    o.up_z = 16'(clip14(rnd_shift(rx * fy, 14)));
    return o;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: random stall and compare on each transfer
  always @(posedge clk) begin
    out_item_t w;
    out_stall <= !calm && ($urandom_range(99) < 29);
    if (!rst && out_valid && !out_stall) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result transfer", $time);
      end else begin
        w = pending_frames.pop_front();
        check_field("pos_x", w.pos_x, out_data.pos_x);
        check_field("pos_z", w.pos_z, out_data.pos_z);
        check_field("fwd_x", w.fwd_x, out_data.fwd_x);
        check_field("fwd_y", w.fwd_y, out_data.fwd_y);
        check_field("fwd_z", w.fwd_z, out_data.fwd_z);
        check_field("right_x", w.right_x, out_data.right_x);
        check_field("right_z", w.right_z, out_data.right_z);
        check_field("up_x", w.up_x, out_data.up_x);
        check_field("up_y", w.up_y, out_data.up_y);
        check_field("up_z", w.up_z, out_data.up_z);
      end
    end
  end

  // one frame transfer, with random idle cycles ahead of it
  task automatic send_frame(in_item_t f, bit typed, out_item_t want);
    out_item_t p;
    while (!calm && ($urandom_range(99) < 29)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (in_stall);
    p = camera_frame(f);
    pending_frames.push_back(typed ? want : p);
    frames_sent++;
  endtask

  task automatic write_speed(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cam_speed = v;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t random_frame(in_item_t prev);
    in_item_t f;
    f = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    case ($urandom_range(9))
      0: f.frame_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1, 2, 3, 4, 5: f.frame_time = 16'($urandom_range(4000));
      default: ;
    endcase
    // mostly small cursor motion, sometimes a jump anywhere
    if ($urandom_range(9) < 8) begin
      f.cursor_x = prev.cursor_x + 16'($signed($urandom_range(80)) - 40);
      f.cursor_y = prev.cursor_y + 16'($signed($urandom_range(80)) - 40);
    end
    return f;
  endfunction

  initial begin
    in_item_t last;
    logic [15:0] speeds[5];
    cam_speed = 16'd1280;
    cam_heading = '0;
    cam_tilt = 0;
    cam_px = '0;
    cam_pz = '0;
    cam_last_x = 0;
    cam_last_y = 0;
    cam_seen = 1'b0;
    speeds = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'($urandom)};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at the reset speed
    foreach (dir_rows[i]) send_frame(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    last = dir_rows[13].item;
    drain();

    // random phases, one speed setting each, one without any idling
    foreach (speeds[k]) begin
      write_speed(speeds[k]);
      calm = (k == 2);
      repeat (PHASE_ITEMS) begin
        last = random_frame(last);
        send_frame(last, 1'b0, '0);
      end
      drain();
      calm = 1'b0;
    end

    $display("sent %0d frames over six speed settings, %0d results checked",
             frames_sent, frames_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
